// ----- rtl/core/bbem_pkg.sv -----
// ----------------------------------------------------------------------------
// bbem_pkg
// Types, constants and brightness class functions shared by the brightness
// band edge marker.
// ----------------------------------------------------------------------------
package bbem_pkg;

    localparam int MAX_LINE   = 1024;
    localparam int HEIGHT_MAX = 1024;
    localparam int DIM_MIN    = 2;

    localparam int DIM_W   = 11;
    localparam int COL_W   = $clog2(MAX_LINE);
    localparam int ROW_W   = $clog2(HEIGHT_MAX);
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int SUM_W   = $clog2(3 * 255 + 1);
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int THR_TOP   = 625;
    localparam int THR_STEP  = 25;
    localparam int THR_COUNT = 4;
    localparam int BAND_HIGH = 750;
    localparam int BAND_TOP  = 765;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dims_t;

    typedef struct packed {
        pixel_t           pix;
        pixel_t           pend;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             emit_mid;
        logic             emit_left;
        logic             emit_corner;
        logic             right_ok;
    } stage_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [COL_W-1:0] right_addr;
        pixel_t           data;
    } line_access_t;

    typedef enum logic [1:0] {
        BAND_DARK,
        BAND_BRIGHT,
        BAND_NEAR
    } band_t;

    localparam pixel_t EDGE_PIXEL = '{red: CHAN_FULL, green: CHAN_ZERO, blue: CHAN_ZERO};

    function automatic logic [SUM_W-1:0] pixel_sum(input pixel_t p);
        return SUM_W'(p.red) + SUM_W'(p.green) + SUM_W'(p.blue);
    endfunction

    function automatic band_t band_code(input logic [SUM_W-1:0] sum,
                                        input logic [SUM_W-1:0] thr);
        band_t code;
        if (sum < thr) begin
            code = BAND_DARK;
        end else if (sum < SUM_W'(BAND_HIGH)) begin
            code = BAND_BRIGHT;
        end else if (sum < SUM_W'(BAND_TOP)) begin
            code = BAND_NEAR;
        end else begin
            code = BAND_DARK;
        end
        return code;
    endfunction

    function automatic logic pixels_differ(input pixel_t a, input pixel_t b);
        logic [SUM_W-1:0] sa;
        logic [SUM_W-1:0] sb;
        logic [SUM_W-1:0] thr;
        logic             diff;
        sa   = pixel_sum(a);
        sb   = pixel_sum(b);
        diff = 1'b0;
        for (int i = 0; i < THR_COUNT; i++) begin
            thr  = SUM_W'(THR_TOP - i * THR_STEP);
            diff = diff | (band_code(sa, thr) != band_code(sb, thr));
        end
        return diff;
    endfunction

endpackage

// ----- rtl/core/bbem_ram.sv -----
// ----------------------------------------------------------------------------
// bbem_ram
// Generic RAM with one write port and two registered read ports. A read of
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bbem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/core/bbem_cfg.sv -----
// ----------------------------------------------------------------------------
// bbem_cfg
// APB register file for the frame size, with the clamped dimensions that the
// raster logic works with.
// ----------------------------------------------------------------------------
module bbem_cfg import bbem_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output dims_t             dims
);

    typedef enum logic {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    logic [DIM_W-1:0] line_width_reg;
    logic [DIM_W-1:0] line_width_next;
    logic [DIM_W-1:0] frame_height_reg;
    logic [DIM_W-1:0] frame_height_next;
    reg_index_t       index;
    logic             write_en;

    assign index    = reg_index_t'(paddr[2]);
    assign write_en = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (write_en) begin
            case (index)
                REG_LINE_WIDTH:   line_width_next   = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[DIM_W-1:0];
                default:          line_width_next   = line_width_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= DIM_W'(960);
            frame_height_reg <= DIM_W'(720);
        end else begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb begin
        case (index)
            REG_LINE_WIDTH:   prdata = DATA_W'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (line_width_reg < DIM_W'(DIM_MIN)) begin
            dims.width = DIM_W'(DIM_MIN);
        end else if (line_width_reg > DIM_W'(MAX_LINE)) begin
            dims.width = DIM_W'(MAX_LINE);
        end else begin
            dims.width = line_width_reg;
        end
        if (frame_height_reg < DIM_W'(DIM_MIN)) begin
            dims.height = DIM_W'(DIM_MIN);
        end else if (frame_height_reg > DIM_W'(HEIGHT_MAX)) begin
            dims.height = DIM_W'(HEIGHT_MAX);
        end else begin
            dims.height = frame_height_reg;
        end
    end

endmodule

// ----- rtl/core/bbem_raster.sv -----
// ----------------------------------------------------------------------------
// bbem_raster
// Input stage: tracks the raster position, drives the line store and holds
// the accepted pixel with the list of results it causes.
// ----------------------------------------------------------------------------
module bbem_raster import bbem_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dims_t             dims,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAN_W-1:0] s_pixel_red,
    input  logic [CHAN_W-1:0] s_pixel_green,
    input  logic [CHAN_W-1:0] s_pixel_blue,
    input  logic              stage_done,
    output logic              stage_valid,
    output stage_t            stage,
    output line_access_t      line_access
);

    logic             stage_valid_reg;
    logic             stage_valid_next;
    stage_t           stage_reg;
    pixel_t           pend_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             accept;
    logic             restart;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             col_end;
    logic             last_row;
    pixel_t           pix;

    assign pix      = '{red: s_pixel_red, green: s_pixel_green, blue: s_pixel_blue};
    assign s_ready  = !stage_valid_reg || stage_done;
    assign accept   = s_valid && s_ready;

    assign restart  = ({1'b0, col_reg} >= dims.width) || ({1'b0, row_reg} >= dims.height);
    assign col      = restart ? '0 : col_reg;
    assign row      = restart ? '0 : row_reg;
    assign col_end  = ({1'b0, col} == dims.width - DIM_W'(1));
    assign last_row = ({1'b0, row} == dims.height - DIM_W'(1));

    always_comb begin
        col_next         = col_reg;
        row_next         = row_reg;
        stage_valid_next = stage_valid_reg;
        if (stage_done) begin
            stage_valid_next = 1'b0;
        end
        if (accept) begin
            stage_valid_next = 1'b1;
            if (col_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row + ROW_W'(1);
            end else begin
                col_next = col + COL_W'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            pend_reg        <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            if (accept) begin
                pend_reg <= pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg.pix         <= pix;
            stage_reg.pend        <= pend_reg;
            stage_reg.col         <= col;
            stage_reg.row         <= row;
            stage_reg.emit_mid    <= (row != '0);
            stage_reg.emit_left   <= last_row && (col != '0);
            stage_reg.emit_corner <= last_row && col_end;
            stage_reg.right_ok    <= !col_end;
        end
    end

    assign stage_valid            = stage_valid_reg;
    assign stage                  = stage_reg;
    assign line_access.en         = accept;
    assign line_access.addr       = col;
    assign line_access.right_addr = col + COL_W'(1);
    assign line_access.data       = pix;

endmodule

// ----- rtl/core/bbem_mark.sv -----
// ----------------------------------------------------------------------------
// bbem_mark
// Edge decision and result register. Emits the held pixel's results one per
// cycle unless stalled, in order, and frees the input stage after the last.
// ----------------------------------------------------------------------------
module bbem_mark import bbem_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              stage_valid,
    input  stage_t            stage,
    input  pixel_t            self_pix,
    input  pixel_t            right_pix,
    output logic              stage_done,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COL_W-1:0]  m_out_column,
    output logic [ROW_W-1:0]  m_out_row,
    output logic [CHAN_W-1:0] m_out_red,
    output logic [CHAN_W-1:0] m_out_green,
    output logic [CHAN_W-1:0] m_out_blue,
    output logic              m_is_edge,
    output logic              m_last_of_run
);

    typedef enum logic [1:0] {
        RES_MID    = 2'd0,
        RES_LEFT   = 2'd1,
        RES_CORNER = 2'd2
    } res_kind_t;

    localparam int RES_N = 3;

    logic [RES_N-1:0] sent_reg;
    logic [RES_N-1:0] sent_next;
    logic [RES_N-1:0] pending;
    logic [RES_N-1:0] sel;
    logic [RES_N-1:0] remaining;
    res_kind_t        kind;
    logic             out_load;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    pixel_t           pix_reg;
    logic             edge_reg;
    logic             last_reg;
    logic [COL_W-1:0] res_col;
    logic [ROW_W-1:0] res_row;
    pixel_t           res_pix;
    logic             res_edge;

    assign pending = {stage.emit_corner, stage.emit_left, stage.emit_mid} & ~sent_reg;

    always_comb begin
        if (pending[RES_MID]) begin
            kind = RES_MID;
        end else if (pending[RES_LEFT]) begin
            kind = RES_LEFT;
        end else begin
            kind = RES_CORNER;
        end
    end

    assign sel        = RES_N'(1) << kind;
    assign remaining  = pending & ~sel;
    assign out_load   = stage_valid && (pending != '0) && (!m_valid_reg || m_ready);
    assign stage_done = stage_valid && ((pending == '0) || (out_load && (remaining == '0)));

    always_comb begin
        case (kind)
            RES_MID: begin
                res_col  = stage.col;
                res_row  = stage.row - ROW_W'(1);
                res_pix  = self_pix;
                res_edge = pixels_differ(self_pix, stage.pix)
                        || (stage.right_ok && pixels_differ(self_pix, right_pix));
            end
            RES_LEFT: begin
                res_col  = stage.col - COL_W'(1);
                res_row  = stage.row;
                res_pix  = stage.pend;
                res_edge = pixels_differ(stage.pend, stage.pix);
            end
            default: begin
                res_col  = stage.col;
                res_row  = stage.row;
                res_pix  = stage.pix;
                res_edge = 1'b0;
            end
        endcase
    end

    always_comb begin
        sent_next    = sent_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            sent_next    = sent_reg | sel;
        end
        if (stage_done) begin
            sent_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sent_reg    <= sent_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            col_reg  <= res_col;
            row_reg  <= res_row;
            pix_reg  <= res_edge ? EDGE_PIXEL : res_pix;
            edge_reg <= res_edge;
            last_reg <= (remaining == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_column  = col_reg;
    assign m_out_row     = row_reg;
    assign m_out_red     = pix_reg.red;
    assign m_out_green   = pix_reg.green;
    assign m_out_blue    = pix_reg.blue;
    assign m_is_edge     = edge_reg;
    assign m_last_of_run = last_reg;

endmodule

// ----- rtl/core/brightness_band_edge_marker_unit.sv -----
// ----------------------------------------------------------------------------
// brightness_band_edge_marker_unit
// Marks brightness band changes in a raster RGB stream as pure red pixels.
//
// Pixels enter row by row on the s_ channel. Each pixel of row r >= 1 yields
// the decision for the pixel above it, which is compared with its right
// neighbor in the line store and the pixel below; the last row also yields
// the decisions for its own pixels, so an input causes zero to three results
// on the m_ channel, each with its column and row, the last one flagged.
// A pixel's first result passes the input stage and result register before
// it is valid on the m_ ports. While the receiver does not stall, one pixel
// is taken per cycle wherever it causes at most one result; in the last
// row a pixel that causes two or three results holds the input until its
// last result is taken, as the result register loads one result per cycle.
// When the receiver stalls, the held result stays on the m_ ports and one
// further pixel is held in the input stage before s_ready falls.
// Reset clears the raster position and empties both stages; the line store
// needs no clearing, since row 0 reads nothing from it. The frame size is
// set through the APB port: line_width at 0x0, frame_height at 0x4.
// ----------------------------------------------------------------------------
module brightness_band_edge_marker_unit import bbem_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAN_W-1:0] s_pixel_red,
    input  logic [CHAN_W-1:0] s_pixel_green,
    input  logic [CHAN_W-1:0] s_pixel_blue,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COL_W-1:0]  m_out_column,
    output logic [ROW_W-1:0]  m_out_row,
    output logic [CHAN_W-1:0] m_out_red,
    output logic [CHAN_W-1:0] m_out_green,
    output logic [CHAN_W-1:0] m_out_blue,
    output logic              m_is_edge,
    output logic              m_last_of_run
);

    dims_t            dims;
    stage_t           stage;
    logic             stage_valid;
    logic             stage_done;
    line_access_t     line_access;
    logic [PIX_W-1:0] self_data;
    logic [PIX_W-1:0] right_data;

    bbem_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    bbem_raster u_raster (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dims          (dims),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_red   (s_pixel_red),
        .s_pixel_green (s_pixel_green),
        .s_pixel_blue  (s_pixel_blue),
        .stage_done    (stage_done),
        .stage_valid   (stage_valid),
        .stage         (stage),
        .line_access   (line_access)
    );

    bbem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .aclk    (aclk),
        .we      (line_access.en),
        .waddr   (line_access.addr),
        .wdata   (line_access.data),
        .re      (line_access.en),
        .raddr_a (line_access.addr),
        .raddr_b (line_access.right_addr),
        .rdata_a (self_data),
        .rdata_b (right_data)
    );

    bbem_mark u_mark (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage_valid   (stage_valid),
        .stage         (stage),
        .self_pix      (pixel_t'(self_data)),
        .right_pix     (pixel_t'(right_data)),
        .stage_done    (stage_done),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_column  (m_out_column),
        .m_out_row     (m_out_row),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_is_edge     (m_is_edge),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ----- rtl/core/bbem_checker.sv -----
// ----------------------------------------------------------------------------
// bbem_checker
// Port-level assertions for the brightness band edge marker, bound to the
// top level.
// ----------------------------------------------------------------------------
module bbem_checker import bbem_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [COL_W-1:0]  m_out_column,
    input logic [ROW_W-1:0]  m_out_row,
    input logic [CHAN_W-1:0] m_out_red,
    input logic [CHAN_W-1:0] m_out_green,
    input logic [CHAN_W-1:0] m_out_blue,
    input logic              m_is_edge,
    input logic              m_last_of_run
);

    // After reset both stages are empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_column) && $stable(m_out_row)
            && $stable(m_out_red) && $stable(m_out_green) && $stable(m_out_blue)
            && $stable(m_is_edge) && $stable(m_last_of_run))
        else $error("stalled result changed");

    // An edge result always carries pure red.
    a_edge_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_edge |-> m_out_red == CHAN_FULL && m_out_green == CHAN_ZERO
            && m_out_blue == CHAN_ZERO)
        else $error("edge result is not pure red");

    // The results of one pixel follow each other without a gap.
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("gap inside a run of results");

endmodule

bind brightness_band_edge_marker_unit bbem_checker u_checker (.*);
